// File: rtl/floor_divmod_64_by_32_top_macros.svh
// ----------------------------------------------------------------------------
// Floor divide assertion macros
// Shared concurrent assertion forms for the floor divider.
// ----------------------------------------------------------------------------
`ifndef FLOOR_DIVMOD_64_BY_32_TOP_MACROS_SVH
`define FLOOR_DIVMOD_64_BY_32_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FDM_ASSERT_NOW(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FDM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: rtl/fdm_pkg.sv
// ----------------------------------------------------------------------------
// Floor divide package
// Request, response and inter-cell types for the 64 by 32 floor divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdm_pkg;

    localparam int W = 32;
    localparam int DW = 2 * W;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [W-1:0]        dividend_low;
        logic signed [W-1:0] dividend_high;
        logic [W-1:0]        divisor_value;
    } t_in_req;

    typedef struct packed {
        logic signed [W-1:0] quotient_value;
        logic [W-1:0]        remainder_value;
        logic [1:0]          status_code;
    } t_out_rsp;

    typedef struct packed {
        logic          valid;
        logic          neg;
        logic          zero;
        logic [W-1:0]  rem;
        logic [DW-1:0] work;
        logic [W-1:0]  div;
    } t_cell_bus;

endpackage

// File: rtl/fdm_cell.sv
// ----------------------------------------------------------------------------
// Floor divide cell
// One restoring division step: retires one quotient bit per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdm_cell import fdm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_cell_bus i_bus,
    output t_cell_bus o_bus
);

    t_cell_bus r_bus;
    logic [W:0] trial;
    logic [W:0] diff;
    logic       take;

    always_comb begin
        trial = {i_bus.rem, i_bus.work[DW-1]};
        diff  = trial - {1'b0, i_bus.div};
        take  = trial >= {1'b0, i_bus.div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_adv) begin
            r_bus.valid <= i_bus.valid;
        end
        if (i_adv) begin
            r_bus.neg  <= i_bus.neg;
            r_bus.zero <= i_bus.zero;
            r_bus.div  <= i_bus.div;
            r_bus.rem  <= take ? diff[W-1:0] : trial[W-1:0];
            r_bus.work <= {i_bus.work[DW-2:0], take};
        end
    end

    assign o_bus = r_bus;

endmodule

// File: rtl/fdm_post.sv
// ----------------------------------------------------------------------------
// Floor divide post stage
// Rounds toward minus infinity, applies the sign and sets the status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdm_post import fdm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_cell_bus i_bus,
    output logic      o_valid,
    output t_out_rsp  o_rsp
);

    logic          r_fix_valid;
    logic          r_fix_neg;
    logic          r_fix_zero;
    logic [DW-1:0] r_fix_qmag;
    logic [W-1:0]  r_fix_rem;
    logic          r_out_valid;
    t_out_rsp      r_out_rsp;

    logic          fix;
    logic [W-1:0]  neg_quo;
    t_out_rsp      n_out_rsp;

    assign fix = i_bus.neg && (i_bus.rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_fix_valid <= i_bus.valid;
            r_out_valid <= r_fix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_fix_neg  <= i_bus.neg;
            r_fix_zero <= i_bus.zero;
            r_fix_qmag <= i_bus.work + {{(DW-1){1'b0}}, fix};
            r_fix_rem  <= fix ? (i_bus.div - i_bus.rem) : i_bus.rem;
            r_out_rsp  <= n_out_rsp;
        end
    end

    always_comb begin
        neg_quo = '0 - r_fix_qmag[W-1:0];
        n_out_rsp.quotient_value  = r_fix_neg ? neg_quo : r_fix_qmag[W-1:0];
        n_out_rsp.remainder_value = r_fix_rem;
        n_out_rsp.status_code     = ST_OK;
        if (r_fix_zero) begin
            n_out_rsp.quotient_value  = '0;
            n_out_rsp.remainder_value = '0;
            n_out_rsp.status_code     = ST_DIV_ZERO;
        end else if (r_fix_neg) begin
            if (r_fix_qmag > {{W{1'b0}}, 1'b1, {(W-1){1'b0}}}) begin
                n_out_rsp.status_code = ST_OVERFLOW;
            end
        end else if (r_fix_qmag > {{(W+1){1'b0}}, {(W-1){1'b1}}}) begin
            n_out_rsp.status_code = ST_OVERFLOW;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out_rsp;

endmodule

// File: rtl/floor_divmod_64_by_32_top.sv
// ----------------------------------------------------------------------------
// Floor divide 64 by 32
// Signed 64-bit dividend over unsigned 32-bit divisor, floor rounding.
// ----------------------------------------------------------------------------
// The divider accepts one request per clock while o_stall is low. A head
// register takes the dividend magnitude, a chain of 64 cells retires one
// quotient bit each, and a fix and an output register round toward minus
// infinity and register the response. While a response waits at the output,
// the whole chain holds, so o_stall follows i_stall whenever o_valid is high.
`timescale 1ns / 1ps

`include "floor_divmod_64_by_32_top_macros.svh"

module floor_divmod_64_by_32_top import fdm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_rsp o_rsp
);

    t_cell_bus     r_head;
    t_cell_bus     chain [DW+1];
    logic          adv;
    logic [DW-1:0] bits;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;
    assign bits    = {i_req.dividend_high, i_req.dividend_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else if (adv) begin
            r_head.valid <= i_valid;
        end
        if (adv) begin
            r_head.neg  <= bits[DW-1];
            r_head.zero <= (i_req.divisor_value == '0);
            r_head.rem  <= '0;
            r_head.work <= bits[DW-1] ? ('0 - bits) : bits;
            r_head.div  <= i_req.divisor_value;
        end
    end

    assign chain[0] = r_head;

    for (genvar g = 0; g < DW; g++) begin : g_cell
        fdm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_bus   (chain[g]),
            .o_bus   (chain[g+1])
        );
    end

    fdm_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_bus   (chain[DW]),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    `FDM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_rsp), "Stalled response changed.")
    `FDM_ASSERT_NOW(a_zero_rsp, i_clk, i_rst_n,
        o_valid && (o_rsp.status_code == ST_DIV_ZERO),
        (o_rsp.quotient_value == '0) && (o_rsp.remainder_value == '0),
        "Divide by zero response carries nonzero data.")
    `FDM_ASSERT_NOW(a_stall_free, i_clk, i_rst_n, !i_stall, !o_stall,
        "Input stalled without output back-pressure.")

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Floor divide 64 by 32 testbench
// Sends directed and random division requests through the valid/stall
// handshake and checks every response against a floor-division predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import fdm_pkg::*;

    localparam int LATENCY_CYCLES = 67;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_in_req  i_req   = '0;
    logic     o_stall;
    logic     o_valid;
    t_out_rsp o_rsp;

    t_out_rsp floor_results_due[$];
    t_out_rsp want_rsp;
    int       fail_count    = 0;
    int       tx_idle_pct   = 0;
    int       rx_stall_pct  = 0;
    int       hold_seq      = 0;
    int       hold_seen     = 0;
    int       hold_left     = 0;
    int       quiet_cycles  = 0;

    floor_divmod_64_by_32_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_out_rsp floor_divide(input t_in_req req);
        logic [63:0] bits;
        logic [63:0] mag;
        logic [63:0] qmag;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] div;
        logic        neg;
        t_out_rsp    rsp;
        rsp  = '0;
        bits = {req.dividend_high, req.dividend_low};
        div  = {32'd0, req.divisor_value};
        neg  = bits[63];
        if (div == 64'd0) begin
            rsp.status_code = ST_DIV_ZERO;
            return rsp;
        end
        mag  = neg ? (64'd0 - bits) : bits;
        qmag = mag / div;
        rem  = mag % div;
        rsp.status_code = ST_OK;
        if (neg) begin
            if (rem != 64'd0) begin
                qmag = qmag + 64'd1;
                rem  = div - rem;
            end
            quo = 64'd0 - qmag;
            if (qmag > 64'h8000_0000) begin
                rsp.status_code = ST_OVERFLOW;
            end
        end else begin
            quo = qmag;
            if (qmag > 64'h7FFF_FFFF) begin
                rsp.status_code = ST_OVERFLOW;
            end
        end
        rsp.quotient_value  = quo[31:0];
        rsp.remainder_value = rem[31:0];
        return rsp;
    endfunction

    function automatic t_in_req make_req(input logic [31:0] hi, input logic [31:0] lo,
                                         input logic [31:0] div);
        t_in_req req;
        req.dividend_low  = lo;
        req.dividend_high = hi;
        req.divisor_value = div;
        return req;
    endfunction

    function automatic t_in_req random_request();
        t_in_req     req;
        logic [31:0] d;
        logic [31:0] x;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] bits;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            d = 32'd0;
        end else if (pick < 28) begin
            d = $urandom_range(1, 16);
        end else if (pick < 40) begin
            d = 32'hFFFF_FFFF - $urandom_range(0, 3);
        end else if (pick < 70) begin
            d = $urandom;
        end else begin
            d = $urandom >> $urandom_range(0, 31);
        end
        x = $urandom;
        case ($urandom_range(3))
            0: begin
                bits = {$urandom, $urandom};
            end
            1: begin
                bits = {32'd0, 32'($urandom_range(0, 1000))};
                if ($urandom_range(1)) begin
                    bits = 64'd0 - bits;
                end
            end
            2: begin
                case ($urandom_range(5))
                    0: q = 64'h0000_0000_7FFF_FFFF;
                    1: q = 64'h0000_0000_8000_0000;
                    2: q = 64'hFFFF_FFFF_8000_0000;
                    3: q = 64'hFFFF_FFFF_7FFF_FFFF;
                    4: q = {{32{x[31]}}, x};
                    default: q = 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
                r = (d == 32'd0) ? 64'd0 : 64'($urandom % d);
                bits = q * {32'd0, d} + r;
            end
            default: begin
                case ($urandom_range(3))
                    0: bits = {32'h0000_0000, x};
                    1: bits = {32'hFFFF_FFFF, x};
                    2: bits = {32'h7FFF_FFFF, x};
                    default: bits = {32'h8000_0000, x};
                endcase
            end
        endcase
        req = make_req(bits[63:32], bits[31:0], d);
        return req;
    endfunction

    task automatic send_request(input t_in_req req);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (floor_results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    task automatic test_directed_cases();
        set_idling(0, 0);
        send_request(make_req(32'h0000_0000, 32'h0000_0000, 32'd0));
        send_request(make_req(32'h8000_0000, 32'h0000_0000, 32'd0));
        send_request(make_req(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0));
        send_request(make_req(32'h0000_0000, 32'h0000_0000, 32'd5));
        send_request(make_req(32'h0000_0000, 32'h0000_0007, 32'd2));
        send_request(make_req(32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'd2));
        send_request(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
        send_request(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_req(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1));
        send_request(make_req(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_req(32'h8000_0000, 32'h0000_0000, 32'd1));
        send_request(make_req(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
        send_request(make_req(32'h8000_0000, 32'h0000_0000, 32'h8000_0000));
        send_request(make_req(32'h0000_0000, 32'h7FFF_FFFF, 32'd1));
        send_request(make_req(32'h0000_0000, 32'h8000_0000, 32'd1));
        send_request(make_req(32'hFFFF_FFFF, 32'h8000_0000, 32'd1));
        send_request(make_req(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1));
        send_request(make_req(32'hFFFF_FFFF, 32'h0000_0000, 32'd2));
        send_request(make_req(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd2));
        send_request(make_req(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAB));
        send_request(make_req(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555));
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        set_idling(tx_pct, rx_pct);
        repeat (count) begin
            send_request(random_request());
        end
    endtask

    task automatic test_output_hold();
        set_idling(0, 0);
        hold_seq <= hold_seq + 1;
        repeat (100) begin
            send_request(random_request());
        end
    endtask

    task automatic test_pause_for_results();
        set_idling(10, 20);
        repeat (20) begin
            send_request(random_request());
        end
        wait_for_results();
        repeat (20) begin
            send_request(random_request());
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (floor_results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("Unexpected response: quotient %h remainder %h status %0d",
                             o_rsp.quotient_value, o_rsp.remainder_value,
                             o_rsp.status_code);
                end
            end else begin
                want_rsp = floor_results_due.pop_front();
                if (o_rsp.quotient_value !== want_rsp.quotient_value
                        || o_rsp.remainder_value !== want_rsp.remainder_value
                        || o_rsp.status_code !== want_rsp.status_code) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("Mismatch: expected q %h r %h s %0d, got q %h r %h s %0d",
                                 want_rsp.quotient_value, want_rsp.remainder_value,
                                 want_rsp.status_code, o_rsp.quotient_value,
                                 o_rsp.remainder_value, o_rsp.status_code);
                    end
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            floor_results_due.push_back(floor_divide(i_req));
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d responses outstanding",
                     floor_results_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_traffic(17, 64, 540);
        test_random_traffic(64, 17, 540);
        test_random_traffic(0, 0, 540);
        test_output_hold();
        test_pause_for_results();
        wait_for_results();
        repeat (LATENCY_CYCLES + 10) @(posedge i_clk);
        if (fail_count == 0 && floor_results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/fdm_pkg.sv
rtl/fdm_cell.sv
rtl/fdm_post.sv
rtl/floor_divmod_64_by_32_top.sv
sim/testbench.sv
